// ----- rtl/xbt_pkg.sv -----
// Shared types, byte constants and helper functions of the XML byte tokenizer.
`timescale 1ns / 1ps

package xbt_pkg;

	// Scanner state between two document bytes.
	typedef enum logic [3:0] {
		MODE_BETWEEN = 4'd0,
		MODE_PREFIX  = 4'd1,
		MODE_IDENT   = 4'd2,
		MODE_TEXT    = 4'd3,
		MODE_STR_DQ  = 4'd4,
		MODE_STR_SQ  = 4'd5,
		MODE_CDATA   = 4'd6,
		MODE_HALT    = 4'd7
	} scan_mode_t;

	// Token kinds as they appear on the result stream.
	typedef enum logic [3:0] {
		TK_EOF      = 4'd0,
		TK_LT       = 4'd1,
		TK_LT_SLASH = 4'd2,
		TK_GT       = 4'd3,
		TK_SLASH    = 4'd4,
		TK_EQUALS   = 4'd5,
		TK_IDENT    = 4'd6,
		TK_STRING   = 4'd7,
		TK_CDATA    = 4'd8,
		TK_TEXT     = 4'd9,
		TK_ERROR    = 4'd10
	} tok_t;

	localparam logic KIND_VALUE  = 1'b0;
	localparam logic KIND_RECORD = 1'b1;

	localparam int unsigned MAX_RES = 4;

	// Bundles held between front and back end; a power of two so the pointers wrap.
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_LT      = 8'h3C;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_EQ      = 8'h3D;
	localparam logic [7:0] CH_DQ      = 8'h22;
	localparam logic [7:0] CH_SQ      = 8'h27;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;

	// Prefix count at which the CDATA opener is complete.
	localparam logic [3:0] CDATA_OPEN_LEN = 4'd9;

	// One result item, without its run_end flag.
	typedef struct packed {
		logic       kind;
		tok_t       tok;
		logic [7:0] value;
	} res_t;

	// All results caused by one input byte, oldest in slot 0.
	typedef struct packed {
		logic [2:0]         cnt;
		res_t [MAX_RES-1:0] res;
	} bundle_t;

	// Front to queue.
	typedef struct packed {
		logic    valid;
		bundle_t bundle;
	} push_t;

	// Queue head as seen by the back end.
	typedef struct packed {
		logic    valid;
		bundle_t bundle;
	} head_t;

	// Outcome of starting a token from the between-tokens state.
	typedef struct packed {
		logic       emit;
		res_t       res;
		scan_mode_t mode;
		logic       in_tag;
		logic [3:0] pre;
	} start_t;

	function automatic res_t mk_rec(input tok_t tk);
		res_t r;
		r.kind  = KIND_RECORD;
		r.tok   = tk;
		r.value = 8'h00;
		return r;
	endfunction

	function automatic res_t mk_val(input tok_t tk, input logic [7:0] b);
		res_t r;
		r.kind  = KIND_VALUE;
		r.tok   = tk;
		r.value = b;
		return r;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic logic is_ident(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h30 && b <= 8'h39) || b == 8'h5F || b == 8'h2D || b == 8'h2E;
	endfunction

	// Byte expected at a given position of the "<![CDATA[" opener.
	function automatic logic [7:0] cdata_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0: c = CH_LT;
			4'd1: c = 8'h21;
			4'd2: c = 8'h5B;
			4'd3: c = 8'h43;
			4'd4: c = 8'h44;
			4'd5: c = 8'h41;
			4'd6: c = 8'h54;
			4'd7: c = 8'h41;
			4'd8: c = 8'h5B;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	// Starts a token with byte b while between tokens.
	function automatic start_t start_tok(input logic [7:0] b, input logic tag);
		start_t s;
		s.emit   = 1'b0;
		s.res    = mk_rec(TK_EOF);
		s.mode   = MODE_BETWEEN;
		s.in_tag = tag;
		s.pre    = 4'd0;
		if (!is_space(b)) begin
			if (b == CH_NUL) begin
				s.emit = 1'b1;
				s.mode = MODE_HALT;
			end else if (b == CH_LT) begin
				s.mode = MODE_PREFIX;
				s.pre  = 4'd1;
			end else if (b == CH_GT) begin
				s.in_tag = 1'b0;
				s.emit   = 1'b1;
				s.res    = mk_rec(TK_GT);
			end else if (tag && b == CH_SLASH) begin
				s.emit = 1'b1;
				s.res  = mk_rec(TK_SLASH);
			end else if (tag && b == CH_EQ) begin
				s.emit = 1'b1;
				s.res  = mk_rec(TK_EQUALS);
			end else if (tag && b == CH_DQ) begin
				s.mode = MODE_STR_DQ;
			end else if (tag && b == CH_SQ) begin
				s.mode = MODE_STR_SQ;
			end else if (tag) begin
				s.emit = 1'b1;
				if (is_ident(b)) begin
					s.mode = MODE_IDENT;
					s.res  = mk_val(TK_IDENT, b);
				end else begin
					s.mode = MODE_HALT;
					s.res  = mk_rec(TK_ERROR);
				end
			end else begin
				s.emit = 1'b1;
				s.mode = MODE_TEXT;
				s.res  = mk_val(TK_TEXT, b);
			end
		end
		return s;
	endfunction

endpackage

// ----- rtl/xml_byte_tokenizer.sv -----
// Top level of the XML byte tokenizer: front end, bundle queue and back end.
`timescale 1ns / 1ps
//
// The block lexes an XML document that arrives one byte per transfer on the
// s_axis channel; s_axis_tlast marks the final byte of a buffer. For every
// token it sends the token's content bytes (m_axis_tuser low) and then one
// token record (m_axis_tuser high) on the m_axis channel. m_axis_tlast is set
// on the last result caused by an input byte. A byte may cause no result
// (whitespace, a held '<' or ']') or up to four.
// The front end decodes a byte in the cycle it is accepted and writes all of
// its results as one bundle into a four-entry queue. The back end takes one
// result per cycle from the queue head into the output register while m_axis
// is ready; each result passes through its queue entry and that register
// before m_axis presents it. Throughput is one byte per cycle while bytes
// cause at most one result each and m_axis is ready; a byte with more results
// holds the output until all are sent, and the queue absorbs short bursts of
// those before s_axis_tready falls. A stall on m_axis holds the output register;
// the queue fills and then s_axis_tready goes low until space frees. Reset
// empties the queue, invalidates the output register and returns the scanner
// to the between-tokens state outside any tag, as does the last byte of a buffer.

module xml_byte_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tlast,  // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [3:0] token_kind, [11:4] value_byte, [15:12] zero
	output logic        m_axis_tuser,  // kind
	output logic        m_axis_tlast   // run_end
);
	import xbt_pkg::*;

	push_t push;
	head_t head;
	logic  q_full;
	logic  pop;
	res_t  out_res;

	// Scanner: classifies each byte and forms its result bundle.
	xbt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.q_full   (q_full),
		.push     (push)
	);

	// Decouples the scanner from output stalls.
	xbt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	// Serializes bundles onto the output channel.
	xbt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {4'd0, out_res.value, out_res.tok};
	assign m_axis_tuser = out_res.kind;

endmodule

// ----- rtl/xbt_front.sv -----
// Front end: accepts document bytes, runs the scanner and builds one result bundle per byte that causes any result.
`timescale 1ns / 1ps

module xbt_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     in_byte,
	input  logic           in_last,
	input  logic           q_full,
	output xbt_pkg::push_t push
);
	import xbt_pkg::*;

	scan_mode_t mode_q;
	logic       tag_q;
	logic [3:0] pre_q;
	logic [1:0] held_q;

	scan_mode_t tk_mode;
	logic       tk_tag;
	logic [3:0] tk_pre;
	logic [1:0] tk_held;

	start_t     stn;
	start_t     stp;
	logic       accept;
	res_t [MAX_RES-1:0] r;
	logic [2:0] n;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// stn starts a token with the current tag flag; stp with the tag flag that '<' sets.
	assign stn = start_tok(in_byte, tag_q);
	assign stp = start_tok(in_byte, 1'b1);

	// Next state after the byte, before the end-of-buffer re-arm.
	always_comb begin
		tk_mode = mode_q;
		tk_tag  = tag_q;
		tk_pre  = pre_q;
		tk_held = held_q;
		case (mode_q)
			MODE_PREFIX: begin
				if (in_byte == cdata_char(pre_q)) begin
					if (pre_q + 4'd1 >= CDATA_OPEN_LEN) begin
						tk_mode = MODE_CDATA;
						tk_pre  = 4'd0;
						tk_held = 2'd0;
					end else begin
						tk_pre = pre_q + 4'd1;
					end
				end else if (pre_q == 4'd1 && in_byte == CH_SLASH) begin
					tk_tag  = 1'b1;
					tk_pre  = 4'd0;
					tk_mode = MODE_BETWEEN;
				end else if (pre_q == 4'd1) begin
					tk_tag  = stp.in_tag;
					tk_pre  = stp.pre;
					tk_mode = stp.mode;
				end else begin
					tk_tag  = 1'b1;
					tk_pre  = 4'd0;
					tk_mode = MODE_HALT;
				end
			end
			MODE_IDENT: begin
				if (!is_ident(in_byte)) begin
					tk_tag  = stn.in_tag;
					tk_pre  = stn.pre;
					tk_mode = stn.mode;
				end
			end
			MODE_TEXT: begin
				if (in_byte == CH_LT) begin
					tk_pre  = 4'd1;
					tk_mode = MODE_PREFIX;
				end else if (in_byte == CH_NUL) begin
					tk_mode = MODE_HALT;
				end
			end
			MODE_STR_DQ, MODE_STR_SQ: begin
				if (in_byte == ((mode_q == MODE_STR_DQ) ? CH_DQ : CH_SQ)) begin
					tk_mode = MODE_BETWEEN;
				end else if (in_byte == CH_NUL) begin
					tk_mode = MODE_HALT;
				end
			end
			MODE_CDATA: begin
				if (in_byte == CH_RBRACK) begin
					if (held_q != 2'd2) begin
						tk_held = held_q + 2'd1;
					end
				end else if (in_byte == CH_GT && held_q == 2'd2) begin
					tk_held = 2'd0;
					tk_mode = MODE_BETWEEN;
				end else if (in_byte == CH_NUL) begin
					tk_held = 2'd0;
					tk_mode = MODE_HALT;
				end else begin
					tk_held = 2'd0;
				end
			end
			MODE_BETWEEN: begin
				tk_tag  = stn.in_tag;
				tk_pre  = stn.pre;
				tk_mode = stn.mode;
			end
			default: begin
			end
		endcase
	end

	// Results caused by the byte, in order, followed by the end-of-buffer records.
	always_comb begin
		r = '0;
		n = 3'd0;
		case (mode_q)
			MODE_PREFIX: begin
				if (in_byte == cdata_char(pre_q)) begin
				end else if (pre_q == 4'd1 && in_byte == CH_SLASH) begin
					r[n[1:0]] = mk_rec(TK_LT_SLASH); n = n + 3'd1;
				end else if (pre_q == 4'd1) begin
					r[n[1:0]] = mk_rec(TK_LT); n = n + 3'd1;
					if (stp.emit) begin
						r[n[1:0]] = stp.res; n = n + 3'd1;
					end
				end else begin
					r[n[1:0]] = mk_rec(TK_LT); n = n + 3'd1;
					r[n[1:0]] = mk_rec(TK_ERROR); n = n + 3'd1;
				end
			end
			MODE_IDENT: begin
				if (is_ident(in_byte)) begin
					r[n[1:0]] = mk_val(TK_IDENT, in_byte); n = n + 3'd1;
				end else begin
					r[n[1:0]] = mk_rec(TK_IDENT); n = n + 3'd1;
					if (stn.emit) begin
						r[n[1:0]] = stn.res; n = n + 3'd1;
					end
				end
			end
			MODE_TEXT: begin
				if (in_byte == CH_LT) begin
					r[n[1:0]] = mk_rec(TK_TEXT); n = n + 3'd1;
				end else if (in_byte == CH_NUL) begin
					r[n[1:0]] = mk_rec(TK_ERROR); n = n + 3'd1;
				end else begin
					r[n[1:0]] = mk_val(TK_TEXT, in_byte); n = n + 3'd1;
				end
			end
			MODE_STR_DQ, MODE_STR_SQ: begin
				if (in_byte == ((mode_q == MODE_STR_DQ) ? CH_DQ : CH_SQ)) begin
					r[n[1:0]] = mk_rec(TK_STRING); n = n + 3'd1;
				end else if (in_byte == CH_NUL) begin
					r[n[1:0]] = mk_rec(TK_ERROR); n = n + 3'd1;
				end else begin
					r[n[1:0]] = mk_val(TK_STRING, in_byte); n = n + 3'd1;
				end
			end
			MODE_CDATA: begin
				if (in_byte == CH_RBRACK) begin
					if (held_q == 2'd2) begin
						r[n[1:0]] = mk_val(TK_CDATA, CH_RBRACK); n = n + 3'd1;
					end
				end else if (in_byte == CH_GT && held_q == 2'd2) begin
					r[n[1:0]] = mk_rec(TK_CDATA); n = n + 3'd1;
				end else if (in_byte == CH_NUL) begin
					r[n[1:0]] = mk_rec(TK_ERROR); n = n + 3'd1;
				end else begin
					// Held brackets were not the closer after all: release them first.
					if (held_q != 2'd0) begin
						r[n[1:0]] = mk_val(TK_CDATA, CH_RBRACK); n = n + 3'd1;
					end
					if (held_q == 2'd2) begin
						r[n[1:0]] = mk_val(TK_CDATA, CH_RBRACK); n = n + 3'd1;
					end
					r[n[1:0]] = mk_val(TK_CDATA, in_byte); n = n + 3'd1;
				end
			end
			MODE_BETWEEN: begin
				if (stn.emit) begin
					r[n[1:0]] = stn.res; n = n + 3'd1;
				end
			end
			default: begin
			end
		endcase
		if (in_last) begin
			case (tk_mode)
				MODE_BETWEEN: begin
					r[n[1:0]] = mk_rec(TK_EOF); n = n + 3'd1;
				end
				MODE_PREFIX: begin
					r[n[1:0]] = mk_rec(TK_LT); n = n + 3'd1;
					r[n[1:0]] = mk_rec((tk_pre <= 4'd1) ? TK_EOF : TK_ERROR); n = n + 3'd1;
				end
				MODE_IDENT: begin
					r[n[1:0]] = mk_rec(TK_IDENT); n = n + 3'd1;
					r[n[1:0]] = mk_rec(TK_EOF); n = n + 3'd1;
				end
				MODE_TEXT: begin
					r[n[1:0]] = mk_rec(TK_TEXT); n = n + 3'd1;
					r[n[1:0]] = mk_rec(TK_EOF); n = n + 3'd1;
				end
				MODE_STR_DQ, MODE_STR_SQ, MODE_CDATA: begin
					r[n[1:0]] = mk_rec(TK_ERROR); n = n + 3'd1;
				end
				default: begin
				end
			endcase
		end
		push.valid         = accept && (n != 3'd0);
		push.bundle.cnt    = n;
		push.bundle.res    = r;
	end

	// The last byte of a buffer re-arms the scanner whatever it did.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BETWEEN;
			tag_q  <= 1'b0;
			pre_q  <= 4'd0;
			held_q <= 2'd0;
		end else if (accept) begin
			if (in_last) begin
				mode_q <= MODE_BETWEEN;
				tag_q  <= 1'b0;
				pre_q  <= 4'd0;
				held_q <= 2'd0;
			end else begin
				mode_q <= tk_mode;
				tag_q  <= tk_tag;
				pre_q  <= tk_pre;
				held_q <= tk_held;
			end
		end
	end

	a_pre_only_in_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(pre_q != 4'd0) |-> (mode_q == MODE_PREFIX))
		else $error("prefix count set outside the tag opener");

	a_held_only_in_cdata: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q != 2'd0) |-> (mode_q == MODE_CDATA))
		else $error("brackets held outside a CDATA body");

	a_halt_is_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode_q == MODE_HALT) |-> !push.valid)
		else $error("results produced while halted");

endmodule

// ----- rtl/xbt_queue.sv -----
// Four-entry queue of result bundles between the front and back ends.
`timescale 1ns / 1ps

module xbt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  xbt_pkg::push_t push,
	output logic           full,
	output xbt_pkg::head_t head,
	input  logic           pop
);
	import xbt_pkg::*;

	bundle_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_q;
	logic [Q_PTR_W-1:0]   rd_q;
	logic [Q_PTR_W:0]     cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full        = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign head.valid  = (cnt_q != '0);
	assign head.bundle = mem_q[rd_q];
	assign do_push     = push.valid && !full;
	assign do_pop      = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + Q_PTR_W'(1);
			end
			cnt_q <= cnt_q + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push.valid)
		else $error("bundle pushed into a full queue");

	a_pointers_track_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == (Q_PTR_W+1)'(Q_DEPTH)) |-> (wr_q == rd_q))
		else $error("queue pointers disagree with fill count");

endmodule

// ----- rtl/xbt_back.sv -----
// Back end: drains result bundles one item per cycle, while the output is not stalled, into the output register.
`timescale 1ns / 1ps

module xbt_back (
	input  logic           clk,
	input  logic           arst_n,
	input  xbt_pkg::head_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output xbt_pkg::res_t  out_res,
	output logic           out_last
);
	import xbt_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	res_t       res_q;
	logic       last_q;
	logic       load;
	logic       at_end;

	assign load      = !valid_q || out_ready;
	assign at_end    = ({1'b0, idx_q} + 3'd1 == head.bundle.cnt);
	assign pop       = load && head.valid && at_end;
	assign out_valid = valid_q;
	assign out_res   = res_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= head.valid;
			if (head.valid) begin
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head.valid) begin
			res_q  <= head.bundle.res[idx_q];
			last_q <= at_end;
		end
	end

	a_idx_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid |-> ({1'b0, idx_q} < head.bundle.cnt))
		else $error("drain index beyond the bundle");

	a_partial_bundle_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 2'd0) |-> head.valid)
		else $error("partly drained bundle left the queue");

endmodule
